/* rtl/pixel_histogram_engine_unit_assert.svh */
// Assertion macros for the pixel histogram engine.
// Used by the top level only; no other dependencies.
`ifndef PIXEL_HISTOGRAM_ENGINE_UNIT_ASSERT_SVH
`define PIXEL_HISTOGRAM_ENGINE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication: when ante holds, cons must hold.
`define PHE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("phe assertion failed");
// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define PHE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("phe assertion failed");
`else
`define PHE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PHE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/phe_pkg.sv */
// Shared types and constants of the pixel histogram engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package phe_pkg;

   localparam int NumBins   = 256;
   localparam int BinIdxW   = $clog2(NumBins);
   localparam int PixelW    = 8;
   localparam int CountW    = 24;
   localparam logic [CountW-1:0] BinCeiling = {CountW{1'b1}};

   typedef enum logic [1:0] {
      OP_ACCUM = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DELIVER
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;    // latch index, read bin memory and valid bit
      logic sel_pixel;  // index from pixel value, else from bin select
      logic write;      // write back incremented count
      logic clear;      // drop every bin to zero
      logic load_rsp;   // load result register
   } cmd_type;

endpackage

`default_nettype wire

/* rtl/phe_ctrl.sv */
// Controller state machine of the pixel histogram engine.
// Depends on phe_pkg; drives the datapath through cmd_type.
`default_nettype none

module phe_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire phe_pkg::opcode_type req_opcode,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output phe_pkg::cmd_type         cmd
);
   import phe_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.sel_pixel = (req_opcode == OP_ACCUM);
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_opcode)
                  OP_ACCUM: state_in  = ST_UPDATE;
                  OP_READ:  state_in  = ST_DELIVER;
                  OP_CLEAR: cmd.clear = 1'b1;
                  default:  state_in  = ST_IDLE;
               endcase
            end
         end
         ST_UPDATE: begin
            cmd.write = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_DELIVER: begin
            // hold until the result register is free or being taken
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid: set on load, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/phe_datapath.sv */
// Datapath of the pixel histogram engine: bin memory, valid bits,
// saturating increment and result register. Depends on phe_pkg.
`default_nettype none

module phe_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire phe_pkg::cmd_type              cmd,
   input  wire logic [phe_pkg::PixelW-1:0]    req_pixel_value,
   input  wire logic [phe_pkg::BinIdxW-1:0]   req_bin_select,
   output logic      [phe_pkg::BinIdxW-1:0]   rsp_bin_number,
   output logic      [phe_pkg::CountW-1:0]    rsp_bin_count
);
   import phe_pkg::*;

   logic [CountW-1:0]  mem [NumBins];
   logic [NumBins-1:0] bin_valid_ff;
   logic [BinIdxW-1:0] idx_in, idx_ff;
   logic [CountW-1:0]  rd_data_ff;
   logic               rd_valid_ff;
   logic [CountW-1:0]  cur_count;
   logic               do_write;
   logic [BinIdxW-1:0] rsp_num_ff;
   logic [CountW-1:0]  rsp_cnt_ff;

   // Pick the bin index; the pixel wraps onto the bin range
   assign idx_in = cmd.sel_pixel ? req_pixel_value[BinIdxW-1:0] : req_bin_select;

   // A bin never written since reset or the last clear reads as zero
   assign cur_count = rd_valid_ff ? rd_data_ff : '0;
   assign do_write  = cmd.write && (cur_count != BinCeiling);

   // Bin memory: registered read, one write port
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_data_ff <= mem[idx_in];
      end
      if (do_write) begin
         mem[idx_ff] <= cur_count + 1'b1;
      end
   end

   // Valid bits: cleared all at once at reset and by the clear opcode
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_valid_ff <= '0;
      end else if (cmd.clear) begin
         bin_valid_ff <= '0;
      end else if (do_write) begin
         bin_valid_ff[idx_ff] <= 1'b1;
      end
   end

   // Capture index and valid bit with the memory read
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff      <= idx_in;
         rd_valid_ff <= bin_valid_ff[idx_in];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_num_ff <= idx_ff;
         rsp_cnt_ff <= cur_count;
      end
   end

   assign rsp_bin_number = rsp_num_ff;
   assign rsp_bin_count  = rsp_cnt_ff;

endmodule

`default_nettype wire

/* rtl/pixel_histogram_engine_unit.sv */
// Pixel histogram engine: 256 bins of 24-bit saturating counts.
// Accumulate reads the bin, then writes back the count through the one write port.
// Read loads the result register from ST_DELIVER, which sets rsp_valid; this waits
// while an earlier result is still stalled. Clear and unused opcodes stay idle.
// Synchronous reset zeroes every bin at once through per-bin valid bits; no sweep.
`default_nettype none

`include "pixel_histogram_engine_unit_assert.svh"

module pixel_histogram_engine_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire phe_pkg::opcode_type           req_opcode,
   input  wire logic [phe_pkg::PixelW-1:0]    req_pixel_value,
   input  wire logic [phe_pkg::BinIdxW-1:0]   req_bin_select,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [phe_pkg::BinIdxW-1:0]   rsp_bin_number,
   output logic      [phe_pkg::CountW-1:0]    rsp_bin_count
);
   import phe_pkg::*;

   cmd_type cmd;

   phe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd)
   );

   phe_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_pixel_value (req_pixel_value),
      .req_bin_select  (req_bin_select),
      .rsp_bin_number  (rsp_bin_number),
      .rsp_bin_count   (rsp_bin_count)
   );

   // No new transfer while a write-back is in flight
   `PHE_ASSERT_IMPLY(a_no_accept_on_write, clock, reset, cmd.write, !(req_valid && !req_stall))
   // Never overwrite a result that is still stalled
   `PHE_ASSERT_IMPLY(a_no_rsp_overwrite, clock, reset, cmd.load_rsp, !(rsp_valid && rsp_stall))
   // A read or accumulate blocks the input for the next cycle
   `PHE_ASSERT_NEXT(a_busy_after_op, clock, reset,
      req_valid && !req_stall && (req_opcode == OP_ACCUM || req_opcode == OP_READ), req_stall)

endmodule

`default_nettype wire
